// ===== src/bpla_pkg.sv =====
// ----------------------------------------------------------------------------
// bpla_pkg
// Shared constants, controller state type and the command and status
// structs of the bipolar pulse lobe area block.
// ----------------------------------------------------------------------------
package bpla_pkg;

  localparam int MAX_BINS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int THR_WIDTH   = 15;
  localparam int ASYM_WIDTH  = 32;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_WIDTH  = 3;
  // 16 fraction bits plus one extra bit for rounding to nearest.
  localparam int FRAC_BITS   = 17;

  // Register indexes (byte address is 4 * index).
  localparam logic [0:0] REG_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_PREP,
    ST_SUMS,
    ST_ABS,
    ST_DIV,
    ST_LOAD
  } bpla_state_t;

  typedef struct packed {
    logic step;
    logic prep;
    logic sums;
    logic absv;
    logic div_step;
    logic load;
  } bpla_cmd_t;

  typedef struct packed {
    logic dz;
    logic div_last;
  } bpla_status_t;

endpackage

// ===== src/bpla_regs.sv =====
// ----------------------------------------------------------------------------
// bpla_regs
// Configuration register file: holds the lobe extent threshold.
// ----------------------------------------------------------------------------
module bpla_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bpla_pkg::ADDR_WIDTH-1:0]    cfg_paddr,
  input  logic [bpla_pkg::DATA_WIDTH-1:0]    cfg_pwdata,
  output logic [bpla_pkg::DATA_WIDTH-1:0]    cfg_prdata,
  output logic                               cfg_pready,
  output logic [bpla_pkg::THR_WIDTH-1:0]     threshold
);
  import bpla_pkg::*;

  logic [THR_WIDTH-1:0] threshold_r;
  logic [THR_WIDTH-1:0] threshold_nxt;
  logic                 wr_en;

  // The two low address bits are ignored; bit 2 selects the register.
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite &&
                 (cfg_paddr[ADDR_WIDTH-1] == REG_THRESHOLD);

  always_comb begin
    threshold_nxt = threshold_r;
    if (wr_en) begin
      threshold_nxt = cfg_pwdata[THR_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
    end else begin
      threshold_r <= threshold_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[ADDR_WIDTH-1] == REG_THRESHOLD) begin
      cfg_prdata = DATA_WIDTH'(threshold_r);
    end
  end

  assign cfg_pready = 1'b1;
  assign threshold  = threshold_r;

endmodule

// ===== src/bpla_ctrl.sv =====
// ----------------------------------------------------------------------------
// bpla_ctrl
// Controller: sequences sample accumulation, the end-of-record steps, the
// divider and the output register handshake.
// ----------------------------------------------------------------------------
module bpla_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_last,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  bpla_pkg::bpla_status_t  status,
  output bpla_pkg::bpla_cmd_t     cmd
);
  import bpla_pkg::*;

  bpla_state_t state_r;
  bpla_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCUM: begin
        if (in_valid && in_last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_SUMS;
      end
      ST_SUMS: begin
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.dz || status.div_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          state_nxt = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_ACCUM: begin
        in_ready = 1'b1;
        cmd.step = in_valid;
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
      end
      ST_SUMS: begin
        cmd.sums = 1'b1;
      end
      ST_ABS: begin
        cmd.absv = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = !status.dz;
      end
      ST_LOAD: begin
        cmd.load = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/bpla_dp.sv =====
// ----------------------------------------------------------------------------
// bpla_dp
// Datapath: running prefix sums and lobe markers per sample, lobe extent
// and area selection at the end of a record, a restoring divider for the
// Q16.16 asymmetry and the output register.
// ----------------------------------------------------------------------------
module bpla_dp #(
  parameter int MAX_BINS     = bpla_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_WIDTH = bpla_pkg::SAMPLE_WIDTH_DEF,
  localparam int BW = $clog2(MAX_BINS + 2),
  localparam int SW = SAMPLE_WIDTH + $clog2(MAX_BINS) + 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  bpla_pkg::bpla_cmd_t                  cmd,
  output bpla_pkg::bpla_status_t               status,
  input  logic [bpla_pkg::THR_WIDTH-1:0]       threshold,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample,
  input  logic                                 in_last,
  output logic [BW-1:0]                        out_start_bin,
  output logic [BW-1:0]                        out_cross_bin,
  output logic [BW-1:0]                        out_end_bin,
  output logic signed [SW-2:0]                 out_total_area,
  output logic signed [SW-1:0]                 out_lobe_difference,
  output logic signed [bpla_pkg::ASYM_WIDTH-1:0] out_asymmetry,
  output logic                                 out_divide_by_zero
);
  import bpla_pkg::*;

  localparam int CW = (SAMPLE_WIDTH > THR_WIDTH + 1) ? SAMPLE_WIDTH : THR_WIDTH + 1;
  localparam int NW = SW + 1;
  localparam int QW = NW + FRAC_BITS;
  localparam int EW = (QW > ASYM_WIDTH + 1) ? QW : ASYM_WIDTH + 1;
  localparam int KW = $clog2(QW + 1);

  // Record state.
  logic [BW-1:0]        count_r,     count_nxt;
  logic signed [SW-1:0] run_r,       run_nxt;
  logic                 seen_r,      seen_nxt;
  logic [BW-1:0]        cbin_r,      cbin_nxt;
  logic signed [SW-1:0] sbc_r,       sbc_nxt;
  logic                 sfound_r,    sfound_nxt;
  logic [BW-1:0]        spos_r,      spos_nxt;
  logic signed [SW-1:0] sbs_r,       sbs_nxt;
  logic [BW-1:0]        epos_r,      epos_nxt;
  logic signed [SW-1:0] ste_r,       ste_nxt;
  logic                 thr_zero_r,  thr_zero_nxt;

  // End-of-record pipeline.
  logic [BW-1:0]        sb_r, ineg_r, eb_r;
  logic signed [SW-1:0] aplu_r, amin_r, area_r;
  logic signed [NW-1:0] num_r, diff_r;
  logic                 neg_r, dz_r;
  logic [NW-1:0]        d_r;
  logic [NW-1:0]        rem_r;
  logic [QW-1:0]        q_r;
  logic [KW-1:0]        cnt_r;

  // Output register.
  logic [BW-1:0]           o_sb_r, o_ineg_r, o_eb_r;
  logic signed [SW-2:0]    o_area_r;
  logic signed [SW-1:0]    o_diff_r;
  logic [ASYM_WIDTH-1:0]   o_asym_r;
  logic                    o_dz_r;

  logic signed [CW-1:0] s_cmp, thr_pos, thr_neg;
  logic signed [SW-1:0] s_sum, run_new;
  logic [BW-1:0]        k;
  logic                 room;

  logic [BW-1:0]        n_sel, ineg_sel, sb_sel, eb_sel;
  logic signed [SW-1:0] pneg_sel, ps_sel, pe_sel;

  logic signed [NW-1:0] num_mag_s, diff_mag_s;
  logic [NW:0]          trial;
  logic                 ge;

  logic [EW-1:0]         q_ext;
  logic                  sat;
  logic [ASYM_WIDTH:0]   mag;
  logic [ASYM_WIDTH-1:0] asym;

  // Per-sample accumulation.
  assign s_cmp   = CW'(in_sample);
  assign thr_pos = CW'($signed({1'b0, threshold}));
  assign thr_neg = -thr_pos;
  assign s_sum   = SW'(in_sample);
  assign run_new = run_r + s_sum;
  assign k       = count_r + BW'(1);
  assign room    = (count_r < BW'(MAX_BINS));

  always_comb begin
    count_nxt    = count_r;
    run_nxt      = run_r;
    seen_nxt     = seen_r;
    cbin_nxt     = cbin_r;
    sbc_nxt      = sbc_r;
    sfound_nxt   = sfound_r;
    spos_nxt     = spos_r;
    sbs_nxt      = sbs_r;
    epos_nxt     = epos_r;
    ste_nxt      = ste_r;
    thr_zero_nxt = thr_zero_r;
    if (cmd.step) begin
      if (in_last) begin
        thr_zero_nxt = (threshold == '0);
      end
      if (room) begin
        count_nxt = k;
        run_nxt   = run_new;
        // The first negative sample marks the crossing.
        if (!seen_r && (s_cmp < 0)) begin
          seen_nxt = 1'b1;
          cbin_nxt = k;
          sbc_nxt  = run_r;
          epos_nxt = count_r;
          ste_nxt  = run_r;
        end
        if (!(seen_r || (s_cmp < 0))) begin
          if (s_cmp > thr_pos) begin
            if (!sfound_r) begin
              sfound_nxt = 1'b1;
              spos_nxt   = k;
              sbs_nxt    = run_r;
            end
            epos_nxt = k;
            ste_nxt  = run_new;
          end
        end else if (s_cmp < thr_neg) begin
          epos_nxt = k;
          ste_nxt  = run_new;
        end
      end
    end else if (cmd.prep) begin
      count_nxt  = '0;
      run_nxt    = '0;
      seen_nxt   = 1'b0;
      cbin_nxt   = '0;
      sbc_nxt    = '0;
      sfound_nxt = 1'b0;
      spos_nxt   = '0;
      sbs_nxt    = '0;
      epos_nxt   = '0;
      ste_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      run_r      <= '0;
      seen_r     <= 1'b0;
      cbin_r     <= '0;
      sbc_r      <= '0;
      sfound_r   <= 1'b0;
      spos_r     <= '0;
      sbs_r      <= '0;
      epos_r     <= '0;
      ste_r      <= '0;
      thr_zero_r <= 1'b1;
    end else begin
      count_r    <= count_nxt;
      run_r      <= run_nxt;
      seen_r     <= seen_nxt;
      cbin_r     <= cbin_nxt;
      sbc_r      <= sbc_nxt;
      sfound_r   <= sfound_nxt;
      spos_r     <= spos_nxt;
      sbs_r      <= sbs_nxt;
      epos_r     <= epos_nxt;
      ste_r      <= ste_nxt;
      thr_zero_r <= thr_zero_nxt;
    end
  end

  // Lobe extent and prefix sums at its edges.
  always_comb begin
    n_sel    = count_r;
    ineg_sel = seen_r ? cbin_r : count_r + BW'(1);
    pneg_sel = seen_r ? sbc_r : run_r;
    if (thr_zero_r) begin
      sb_sel = BW'(1);
      ps_sel = '0;
      eb_sel = n_sel;
      pe_sel = run_r;
    end else begin
      sb_sel = sfound_r ? spos_r : ineg_sel;
      ps_sel = sfound_r ? sbs_r : pneg_sel;
      if (seen_r || sfound_r) begin
        eb_sel = epos_r;
        pe_sel = ste_r;
      end else begin
        eb_sel = n_sel + BW'(1);
        pe_sel = run_r;
      end
    end
  end

  assign num_mag_s  = (num_r < 0) ? -num_r : num_r;
  assign diff_mag_s = (diff_r < 0) ? -diff_r : diff_r;

  // One restoring division step: one quotient bit per cycle.
  assign trial = {rem_r, q_r[QW-1]};
  assign ge    = (trial >= {1'b0, d_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      sb_r   <= sb_sel;
      ineg_r <= ineg_sel;
      eb_r   <= eb_sel;
      aplu_r <= (sb_sel < ineg_sel) ? pneg_sel - ps_sel : '0;
      amin_r <= (ineg_sel <= eb_sel) ? pe_sel - pneg_sel : '0;
      area_r <= (sb_sel <= eb_sel) ? pe_sel - ps_sel : '0;
    end
    if (cmd.sums) begin
      num_r  <= NW'(aplu_r) + NW'(amin_r);
      diff_r <= NW'(aplu_r) - NW'(amin_r);
    end
    if (cmd.absv) begin
      neg_r <= (num_r < 0) != (diff_r < 0);
      dz_r  <= (diff_r == '0);
      d_r   <= diff_mag_s;
      rem_r <= '0;
      q_r   <= {num_mag_s, {FRAC_BITS{1'b0}}};
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? NW'(trial - {1'b0, d_r}) : trial[NW-1:0];
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r + KW'(1);
    end
  end

  assign status.dz       = dz_r;
  assign status.div_last = (cnt_r == KW'(QW - 1));

  // Round the 17-fraction-bit quotient half away from zero and saturate.
  assign q_ext = EW'(q_r);
  assign sat   = |q_ext[EW-1:ASYM_WIDTH];
  assign mag   = sat ? {1'b1, {ASYM_WIDTH{1'b0}}}
                     : ({1'b0, q_ext[ASYM_WIDTH-1:0]} + (ASYM_WIDTH+1)'(1)) >> 1;

  always_comb begin
    if (dz_r) begin
      asym = '0;
    end else if (neg_r) begin
      asym = mag[ASYM_WIDTH:ASYM_WIDTH-1] != 2'b00 ? {1'b1, {(ASYM_WIDTH-1){1'b0}}}
                                                   : -mag[ASYM_WIDTH-1:0];
    end else begin
      asym = mag[ASYM_WIDTH:ASYM_WIDTH-1] != 2'b00 ? {1'b0, {(ASYM_WIDTH-1){1'b1}}}
                                                   : mag[ASYM_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      o_sb_r   <= sb_r;
      o_ineg_r <= ineg_r;
      o_eb_r   <= eb_r;
      o_area_r <= area_r[SW-2:0];
      o_diff_r <= diff_r[SW-1:0];
      o_asym_r <= asym;
      o_dz_r   <= dz_r;
    end
  end

  assign out_start_bin       = o_sb_r;
  assign out_cross_bin       = o_ineg_r;
  assign out_end_bin         = o_eb_r;
  assign out_total_area      = o_area_r;
  assign out_lobe_difference = o_diff_r;
  assign out_asymmetry       = $signed(o_asym_r);
  assign out_divide_by_zero  = o_dz_r;

endmodule

// ===== src/bipolar_pulse_lobe_areas.sv =====
// ----------------------------------------------------------------------------
// bipolar_pulse_lobe_areas
// Lobe extent, area, lobe difference and Q16.16 asymmetry of one bipolar
// response record, reported once per record.
// ----------------------------------------------------------------------------
//  Channel  | Signals                               | Moves
//  ---------+---------------------------------------+---------------------------
//  in       | in_valid/in_ready, sample, last       | one sample per request
//  out      | out_valid/out_ready, 7 result fields  | one result per record
//  cfg      | APB: cfg_psel..cfg_pready             | threshold at address 0
//
// Samples are taken at one per cycle. After the last sample in_ready stays low
// through the extent, sums, magnitudes, divide and load states. The divide state
// runs the one-bit-per-cycle restoring divider; a zero lobe difference leaves
// the divide state without dividing.
// Reset is synchronous and clears the record state and the threshold.
// A result held by out_ready low does not stop the next record's samples;
// only loading the following result waits for the output register.
// ----------------------------------------------------------------------------
module bipolar_pulse_lobe_areas #(
  parameter int MAX_BINS     = bpla_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_WIDTH = bpla_pkg::SAMPLE_WIDTH_DEF,
  localparam int BW = $clog2(MAX_BINS + 2),
  localparam int SW = SAMPLE_WIDTH + $clog2(MAX_BINS) + 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_psel,
  input  logic                                   cfg_penable,
  input  logic                                   cfg_pwrite,
  input  logic [bpla_pkg::ADDR_WIDTH-1:0]        cfg_paddr,
  input  logic [bpla_pkg::DATA_WIDTH-1:0]        cfg_pwdata,
  output logic [bpla_pkg::DATA_WIDTH-1:0]        cfg_prdata,
  output logic                                   cfg_pready,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]         in_sample,
  input  logic                                   in_last,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [BW-1:0]                          out_start_bin,
  output logic [BW-1:0]                          out_cross_bin,
  output logic [BW-1:0]                          out_end_bin,
  output logic signed [SW-2:0]                   out_total_area,
  output logic signed [SW-1:0]                   out_lobe_difference,
  output logic signed [bpla_pkg::ASYM_WIDTH-1:0] out_asymmetry,
  output logic                                   out_divide_by_zero
);
  import bpla_pkg::*;

  logic [THR_WIDTH-1:0] threshold;
  bpla_cmd_t            cmd;
  bpla_status_t         status;

  bpla_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .threshold   (threshold)
  );

  bpla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  bpla_dp #(
    .MAX_BINS     (MAX_BINS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .threshold           (threshold),
    .in_sample           (in_sample),
    .in_last             (in_last),
    .out_start_bin       (out_start_bin),
    .out_cross_bin       (out_cross_bin),
    .out_end_bin         (out_end_bin),
    .out_total_area      (out_total_area),
    .out_lobe_difference (out_lobe_difference),
    .out_asymmetry       (out_asymmetry),
    .out_divide_by_zero  (out_divide_by_zero)
  );

endmodule

// ===== src/bpla_checker.sv =====
// ----------------------------------------------------------------------------
// bpla_checker
// Port-level checks of the lobe area block, bound to its top level.
// ----------------------------------------------------------------------------
module bpla_checker #(
  parameter int MAX_BINS     = bpla_pkg::MAX_BINS_DEF,
  parameter int SAMPLE_WIDTH = bpla_pkg::SAMPLE_WIDTH_DEF,
  localparam int BW = $clog2(MAX_BINS + 2),
  localparam int SW = SAMPLE_WIDTH + $clog2(MAX_BINS) + 1
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   in_last,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic [BW-1:0]                          out_start_bin,
  input logic [BW-1:0]                          out_cross_bin,
  input logic [BW-1:0]                          out_end_bin,
  input logic signed [SW-1:0]                   out_lobe_difference,
  input logic signed [bpla_pkg::ASYM_WIDTH-1:0] out_asymmetry,
  input logic                                   out_divide_by_zero
);

  // A waiting result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_start_bin) &&
      $stable(out_end_bin) && $stable(out_asymmetry))
    else $error("result changed while stalled");

  // The end of a record always stops intake for the end-of-record steps.
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("request accepted right after a record's last sample");

  a_cross_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cross_bin != '0)
    else $error("crossing bin is zero");

  a_dz_asym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> out_asymmetry == '0)
    else $error("asymmetry nonzero with zero divisor");

  a_dz_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_divide_by_zero == (out_lobe_difference == '0))
    else $error("zero divisor flag disagrees with lobe difference");

endmodule

bind bipolar_pulse_lobe_areas bpla_checker #(
  .MAX_BINS     (MAX_BINS),
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_bpla_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .in_last             (in_last),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_start_bin       (out_start_bin),
  .out_cross_bin       (out_cross_bin),
  .out_end_bin         (out_end_bin),
  .out_lobe_difference (out_lobe_difference),
  .out_asymmetry       (out_asymmetry),
  .out_divide_by_zero  (out_divide_by_zero)
);
